FILE: rtl/erm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Euler-angle rotation matrix block.
// No dependencies; every other file imports it.
package erm_pkg;

    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;
    localparam int Q       = 30;
    localparam int PROD_W  = 62;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [OUT_W-1:0]   t_entry;
    typedef logic signed [Q+1:0]       t_q30;
    typedef logic [Q:0]                t_u31;
    typedef logic [PROD_W-1:0]         t_prod;

    localparam t_u31 ONE_Q = t_u31'(1) << Q;

    localparam t_u31 C9 = 31'd172272;
    localparam t_u31 HORNER [4] = '{31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713};

    localparam int NUM_TRIG = 6;
    localparam int NUM_OUT  = 9;

    localparam int SX = 0;
    localparam int SY = 1;
    localparam int SZ = 2;
    localparam int CX = 3;
    localparam int CY = 4;
    localparam int CZ = 5;

    localparam int LANE_STAGES  = 8;
    localparam int MERGE_STAGES = 6;

endpackage

FILE: rtl/erm_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channels of the rotation matrix block: angle items in, matrix items out.
// Depends on erm_pkg.
interface erm_angle_if;
    import erm_pkg::*;

    logic   valid;
    logic   ready;
    t_angle angle_x;
    t_angle angle_y;
    t_angle angle_z;

    modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface erm_matrix_if;
    import erm_pkg::*;

    logic   valid;
    logic   ready;
    t_entry m00;
    t_entry m01;
    t_entry m02;
    t_entry m10;
    t_entry m11;
    t_entry m12;
    t_entry m20;
    t_entry m21;
    t_entry m22;

    modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                    output m12, output m20, output m21, output m22, input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                    input m12, input m20, input m21, input m22, output ready);
endinterface

FILE: rtl/erm_sine_lane.sv
`timescale 1ns / 1ps
// One sine lane: quadrant fold and a pipelined Horner polynomial, Q30 result.
// Depends on erm_pkg.
module erm_sine_lane #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output erm_pkg::t_q30         o_sine
);
    import erm_pkg::*;

    localparam int T_PAD = Q + 2 - ANGLE_BITS;

    logic [Q-1:0] w_t;
    t_u31         w_u;
    t_u31         w_sat;

    t_u31 r_u   [6];
    logic r_neg [7];
    t_u31 r_sq  [4];
    t_u31 r_p   [4];
    t_u31 r_mag;
    t_q30 r_sine;

    function automatic t_u31 mulq(t_u31 a, t_u31 b);
        t_prod p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[2*Q:Q];
    endfunction

    assign w_t   = {i_phase[ANGLE_BITS-3:0], {T_PAD{1'b0}}};
    assign w_u   = i_phase[ANGLE_BITS-2] ? (ONE_Q - {1'b0, w_t}) : {1'b0, w_t};
    assign w_sat = (r_mag > ONE_Q) ? ONE_Q : r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u[0]   <= w_u;
            r_neg[0] <= i_phase[ANGLE_BITS-1];
            for (int k = 1; k < 6; k++) begin
                r_u[k] <= r_u[k-1];
            end
            for (int k = 1; k < 7; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_sq[0] <= mulq(r_u[0], r_u[0]);
            for (int k = 1; k < 4; k++) begin
                r_sq[k] <= r_sq[k-1];
            end
            r_p[0] <= HORNER[0] - mulq(C9, r_sq[0]);
            for (int k = 1; k < 4; k++) begin
                r_p[k] <= HORNER[k] - mulq(r_p[k-1], r_sq[k]);
            end
            r_mag  <= mulq(r_u[5], r_p[3]);
            r_sine <= r_neg[6] ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});
        end
    end

    assign o_sine = r_sine;

endmodule

FILE: rtl/erm_merge.sv
`timescale 1ns / 1ps
// Product stage: combines the six sine/cosine lanes into the nine matrix entries.
// Depends on erm_pkg.
module erm_merge #(
    parameter int FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  erm_pkg::t_q30   i_trig  [erm_pkg::NUM_TRIG],
    output erm_pkg::t_entry o_entry [erm_pkg::NUM_OUT]
);
    import erm_pkg::*;

    localparam int L1_N = 11;
    localparam int L2_N = 4;

    localparam int I_SXSZ = 0;
    localparam int I_SYSX = 1;
    localparam int I_CYSX = 2;
    localparam int I_CYCZ = 3;
    localparam int I_SZCX = 4;
    localparam int I_SZCY = 5;
    localparam int I_CZCX = 6;
    localparam int I_SYSZ = 7;
    localparam int I_SYCX = 8;
    localparam int I_CXCY = 9;
    localparam int I_SYCZ = 10;

    localparam int L1_A [L1_N] = '{SX, SY, CY, CY, SZ, SZ, CZ, SY, SY, CX, SY};
    localparam int L1_B [L1_N] = '{SZ, SX, SX, CZ, CX, CY, CX, SZ, CX, CY, CZ};
    localparam int L2_A [L2_N] = '{SY, CY, CZ, CZ};
    localparam int L2_B [L2_N] = '{I_SXSZ, I_SXSZ, I_SYSX, I_CYSX};

    localparam int          SH      = Q - FRAC_BITS;
    localparam t_prod       RND_Q   = t_prod'(1) << (Q - 1);
    localparam logic [32:0] RND_OUT = 33'((1 << SH) >> 1);
    localparam logic [32:0] MAX_OUT = 33'(1) << FRAC_BITS;

    t_prod  r_p1     [L1_N];
    logic   r_n1     [L1_N];
    t_q30   r_trig_d1 [NUM_TRIG];
    t_q30   r_l1     [L1_N];
    t_q30   r_trig_d2 [NUM_TRIG];
    t_prod  r_p2     [L2_N];
    logic   r_n2     [L2_N];
    t_q30   r_l1_d3  [L1_N];
    t_q30   r_sx3;
    t_q30   r_l2     [L2_N];
    t_q30   r_l1_d4  [L1_N];
    t_q30   r_sx4;
    logic signed [32:0] r_sum [NUM_OUT];
    t_entry r_out    [NUM_OUT];

    function automatic t_u31 mag(t_q30 a);
        return a[Q+1] ? t_u31'(-a) : a[Q:0];
    endfunction

    function automatic t_prod mul_mag(t_q30 a, t_q30 b);
        return PROD_W'(mag(a)) * PROD_W'(mag(b));
    endfunction

    function automatic t_q30 round_q(t_prod p, logic neg);
        t_prod s;
        t_q30  m;
        s = p + RND_Q;
        m = $signed({1'b0, s[2*Q:Q]});
        return neg ? -m : m;
    endfunction

    function automatic logic signed [32:0] sx33(t_q30 a);
        return $signed({a[Q+1], a});
    endfunction

    function automatic t_entry to_out(logic signed [32:0] v);
        logic        neg;
        logic [32:0] m;
        logic [32:0] r;
        logic [33:0] s;
        neg = v[32];
        m   = neg ? 33'(-v) : 33'(v);
        r   = (m + RND_OUT) >> SH;
        if (r > MAX_OUT) begin
            r = MAX_OUT;
        end
        s = neg ? (34'd0 - {1'b0, r}) : {1'b0, r};
        return $signed(s[OUT_W-1:0]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < L1_N; k++) begin
                r_p1[k] <= mul_mag(i_trig[L1_A[k]], i_trig[L1_B[k]]);
                r_n1[k] <= i_trig[L1_A[k]][Q+1] ^ i_trig[L1_B[k]][Q+1];
            end
            r_trig_d1 <= i_trig;

            for (int k = 0; k < L1_N; k++) begin
                r_l1[k] <= round_q(r_p1[k], r_n1[k]);
            end
            r_trig_d2 <= r_trig_d1;

            for (int k = 0; k < L2_N; k++) begin
                r_p2[k] <= mul_mag(r_trig_d2[L2_A[k]], r_l1[L2_B[k]]);
                r_n2[k] <= r_trig_d2[L2_A[k]][Q+1] ^ r_l1[L2_B[k]][Q+1];
            end
            r_l1_d3 <= r_l1;
            r_sx3   <= r_trig_d2[SX];

            for (int k = 0; k < L2_N; k++) begin
                r_l2[k] <= round_q(r_p2[k], r_n2[k]);
            end
            r_l1_d4 <= r_l1_d3;
            r_sx4   <= r_sx3;

            r_sum[0] <= sx33(r_l1_d4[I_CYCZ]) - sx33(r_l2[0]);
            r_sum[1] <= 33'sd0 - sx33(r_l1_d4[I_SZCX]);
            r_sum[2] <= sx33(r_l1_d4[I_SYCZ]) + sx33(r_l2[1]);
            r_sum[3] <= sx33(r_l1_d4[I_SZCY]) + sx33(r_l2[2]);
            r_sum[4] <= sx33(r_l1_d4[I_CZCX]);
            r_sum[5] <= sx33(r_l1_d4[I_SYSZ]) - sx33(r_l2[3]);
            r_sum[6] <= 33'sd0 - sx33(r_l1_d4[I_SYCX]);
            r_sum[7] <= sx33(r_sx4);
            r_sum[8] <= sx33(r_l1_d4[I_CXCY]);

            for (int k = 0; k < NUM_OUT; k++) begin
                r_out[k] <= to_out(r_sum[k]);
            end
        end
    end

    assign o_entry = r_out;

endmodule

FILE: rtl/euler_rotation_matrix.sv
`timescale 1ns / 1ps
// Top level: six sine/cosine lanes, the product stage and a two-entry output stage.
// Depends on erm_pkg, erm_ifs, erm_sine_lane and erm_merge.

// Takes one angle triple per clock while ready is high and returns the matrix
// Rz*Rx*Ry, one item per item, in order. A result passes through the sine lanes
// (one multiply per Horner step), the product stage (two rounds of multiply and
// round, then sum and output rounding) and the output register. Sustained rate is
// one item per cycle while the output is taken; a skid register behind the output
// absorbs one stalled item, and ready drops only while that register holds an
// item. Angles use the low ANGLE_BITS bits as phase; entries are Q1.FRAC_BITS,
// saturated to plus or minus one, low 16 bits driven.
module euler_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    erm_angle_if.sink    i_angle,
    erm_matrix_if.source o_matrix
);
    import erm_pkg::*;

    localparam int LAT   = LANE_STAGES + MERGE_STAGES;
    localparam int EXT_W = (ANGLE_BITS > ANGLE_W) ? ANGLE_BITS : ANGLE_W;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    logic                  w_en;
    t_angle                w_angle [3];
    logic [ANGLE_BITS-1:0] w_phase [NUM_TRIG];
    t_q30                  w_trig  [NUM_TRIG];
    t_entry                w_entry [NUM_OUT];
    logic                  w_load_tail_out;
    logic                  w_load_tail_skid;
    logic                  w_load_skid_out;

    logic [LAT-1:0] r_vld;
    logic           r_out_valid;
    logic           r_skid_valid;
    t_entry         r_out_data  [NUM_OUT];
    t_entry         r_skid_data [NUM_OUT];

    assign w_en          = !r_skid_valid;
    assign i_angle.ready = w_en;

    assign w_angle[0] = i_angle.angle_x;
    assign w_angle[1] = i_angle.angle_y;
    assign w_angle[2] = i_angle.angle_z;

    always_comb begin
        logic [EXT_W-1:0] ext;
        for (int k = 0; k < 3; k++) begin
            ext            = EXT_W'($unsigned(w_angle[k]));
            w_phase[k]     = ext[ANGLE_BITS-1:0];
            w_phase[k + 3] = ext[ANGLE_BITS-1:0] + QUARTER;
        end
    end

    for (genvar g = 0; g < NUM_TRIG; g++) begin : g_lane
        erm_sine_lane #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_phase[g]),
            .o_sine  (w_trig[g])
        );
    end

    erm_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_trig  (w_trig),
        .o_entry (w_entry)
    );

    assign w_load_skid_out  = r_skid_valid && o_matrix.ready;
    assign w_load_tail_out  = !r_skid_valid && r_vld[LAT-1] && (!r_out_valid || o_matrix.ready);
    assign w_load_tail_skid = !r_skid_valid && r_vld[LAT-1] && r_out_valid && !o_matrix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_angle.valid};
            end
            if (w_load_skid_out) begin
                r_skid_valid <= 1'b0;
            end else if (w_load_tail_out) begin
                r_out_valid <= 1'b1;
            end else if (w_load_tail_skid) begin
                r_skid_valid <= 1'b1;
            end else if (o_matrix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_skid_out) begin
            r_out_data <= r_skid_data;
        end else if (w_load_tail_out) begin
            r_out_data <= w_entry;
        end
        if (w_load_tail_skid) begin
            r_skid_data <= w_entry;
        end
    end

    assign o_matrix.valid = r_out_valid;
    assign o_matrix.m00   = r_out_data[0];
    assign o_matrix.m01   = r_out_data[1];
    assign o_matrix.m02   = r_out_data[2];
    assign o_matrix.m10   = r_out_data[3];
    assign o_matrix.m11   = r_out_data[4];
    assign o_matrix.m12   = r_out_data[5];
    assign o_matrix.m20   = r_out_data[6];
    assign o_matrix.m21   = r_out_data[7];
    assign o_matrix.m22   = r_out_data[8];

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_tail_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-1] && r_out_valid && !o_matrix.ready) |=> r_skid_valid)
        else $error("item leaving the pipeline was not caught by the skid register");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_matrix.ready) |=> (r_skid_valid && !i_angle.ready))
        else $error("stalled skid item was dropped or input reopened");

endmodule

FILE: tb/erm_matrix_checker.sv
`timescale 1ns / 1ps
// Checker of the rotation matrix block: watches the angle and matrix channels,
// predicts each matrix in fixed point and compares it entry by entry.
// Depends on erm_pkg and erm_ifs.
module erm_matrix_checker #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    erm_angle_if  i_angle,
    erm_matrix_if i_matrix,
    output int    o_fail_count,
    output int    o_pending
);
    import erm_pkg::*;

    typedef logic [NUM_OUT-1:0][OUT_W-1:0] t_matrix;

    localparam int MAX_SHOWN = 10;
    localparam int OUT_SHIFT = Q - FRAC_BITS;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    t_matrix expected_matrices [$];
    int      mismatches = 0;
    int      results_seen = 0;
    string   entry_names [NUM_OUT] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                       "m20", "m21", "m22"};

    function automatic longint unsigned quarter_sine(input longint unsigned u);
        longint unsigned u2;
        longint unsigned acc;
        u2  = (u * u) >> Q;
        acc = 64'(C9);
        for (int k = 0; k < 4; k++) begin
            acc = 64'(HORNER[k]) - ((acc * u2) >> Q);
        end
        acc = (u * acc) >> Q;
        if (acc > 64'(ONE_Q)) begin
            acc = 64'(ONE_Q);
        end
        return acc;
    endfunction

    function automatic longint angle_sine(input logic [ANGLE_BITS-1:0] phase);
        logic [1:0]      quad;
        longint unsigned offs;
        longint unsigned u;
        longint          s;
        quad = phase[ANGLE_BITS-1 -: 2];
        offs = 64'(phase[ANGLE_BITS-3:0]) << (Q + 2 - ANGLE_BITS);
        u    = quad[0] ? (64'(ONE_Q) - offs) : offs;
        s    = $signed(quarter_sine(u));
        return quad[1] ? -s : s;
    endfunction

    function automatic longint mul_round(input longint a, input longint b);
        bit              neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned mag;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        mag = (ua * ub + (64'(1) << (Q - 1))) >> Q;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [OUT_W-1:0] to_entry(input longint v);
        bit              neg;
        longint unsigned mag;
        longint          r;
        neg = v < 0;
        mag = neg ? 64'(-v) : 64'(v);
        mag = (mag + (64'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (mag > (64'(1) << FRAC_BITS)) begin
            mag = 64'(1) << FRAC_BITS;
        end
        r = neg ? -$signed(mag) : $signed(mag);
        return r[OUT_W-1:0];
    endfunction

    function automatic t_matrix predict_matrix(input t_angle ax, input t_angle ay,
                                               input t_angle az);
        logic [ANGLE_BITS-1:0] px, py, pz;
        longint  sx, sy, sz, cx, cy, cz, sxsz, sycz;
        longint  e [NUM_OUT];
        t_matrix res;
        px   = ax[ANGLE_BITS-1:0];
        py   = ay[ANGLE_BITS-1:0];
        pz   = az[ANGLE_BITS-1:0];
        sx   = angle_sine(px);
        sy   = angle_sine(py);
        sz   = angle_sine(pz);
        cx   = angle_sine(px + QUARTER_TURN);
        cy   = angle_sine(py + QUARTER_TURN);
        cz   = angle_sine(pz + QUARTER_TURN);
        sxsz = mul_round(sx, sz);
        sycz = mul_round(sy, cz);
        e[0] = mul_round(cy, cz) - mul_round(sy, sxsz);
        e[1] = -mul_round(sz, cx);
        e[2] = sycz + mul_round(cy, sxsz);
        e[3] = mul_round(sz, cy) + mul_round(mul_round(sy, sx), cz);
        e[4] = mul_round(cz, cx);
        e[5] = mul_round(sy, sz) - mul_round(mul_round(cy, sx), cz);
        e[6] = -mul_round(sy, cx);
        e[7] = sx;
        e[8] = mul_round(cx, cy);
        for (int j = 0; j < NUM_OUT; j++) begin
            res[j] = to_entry(e[j]);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_matrix.valid && i_matrix.ready) begin
                got = {i_matrix.m22, i_matrix.m21, i_matrix.m20, i_matrix.m12, i_matrix.m11,
                       i_matrix.m10, i_matrix.m02, i_matrix.m01, i_matrix.m00};
                if (expected_matrices.size() == 0) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("item %0d: matrix with no angles pending", results_seen);
                    end
                    mismatches++;
                end else begin
                    want = expected_matrices.pop_front();
                    for (int j = 0; j < NUM_OUT; j++) begin
                        if (got[j] !== want[j]) begin
                            if (mismatches < MAX_SHOWN) begin
                                $display("item %0d %s: expected %0d, actual %0d", results_seen,
                                         entry_names[j], $signed(want[j]), $signed(got[j]));
                            end
                            mismatches++;
                        end
                    end
                end
                results_seen++;
            end
            if (i_angle.valid && i_angle.ready) begin
                expected_matrices.push_back(predict_matrix(i_angle.angle_x, i_angle.angle_y,
                                                           i_angle.angle_z));
            end
            o_fail_count <= mismatches;
            o_pending    <= expected_matrices.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top of the rotation matrix testbench: clock, reset, angle stimulus, output
// back-pressure and the verdict. Depends on erm_pkg, erm_ifs, the block and the checker.
module tb;
    import erm_pkg::*;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int RANDOM_ITEMS = 800;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 200;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   results_taken = 0;
    int   cycle_count = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;

    erm_angle_if  angle_ch ();
    erm_matrix_if matrix_ch ();

    euler_rotation_matrix #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_angle (angle_ch),
        .o_matrix(matrix_ch)
    );

    erm_matrix_checker #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_angle     (angle_ch),
        .i_matrix    (matrix_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic offer_angles(input t_angle ax, input t_angle ay, input t_angle az);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            angle_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        angle_ch.valid   <= 1'b1;
        angle_ch.angle_x <= ax;
        angle_ch.angle_y <= ay;
        angle_ch.angle_z <= az;
        @(posedge i_clk);
        while (!angle_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        angle_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_angle random_angle();
        case ($urandom_range(0, 3))
            0:       return t_angle'($urandom_range(0, 7) * 8192 + $urandom_range(0, 8) - 4);
            default: return t_angle'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        angle_ch.valid   <= 1'b0;
        angle_ch.angle_x <= '0;
        angle_ch.angle_y <= '0;
        angle_ch.angle_z <= '0;
        i_rst_n          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_angles(16'sd0, 16'sd0, 16'sd0);
        offer_angles(16'sd16384, 16'sd0, 16'sd0);
        offer_angles(16'sd0, 16'sd16384, 16'sd0);
        offer_angles(16'sd0, 16'sd0, 16'sd16384);
        offer_angles(16'sd16384, 16'sd16384, 16'sd16384);
        offer_angles(-16'sd32768, -16'sd32768, -16'sd32768);
        offer_angles(-16'sd16384, -16'sd16384, -16'sd16384);
        offer_angles(16'sd32767, 16'sd32767, 16'sd32767);
        offer_angles(-16'sd1, -16'sd1, -16'sd1);
        offer_angles(16'sd1, 16'sd1, 16'sd1);
        offer_angles(16'sd16383, 16'sd16385, 16'sd16383);
        offer_angles(16'sd16385, 16'sd16383, 16'sd16385);
        offer_angles(-16'sd16383, -16'sd16385, 16'sd32767);
        offer_angles(16'sd8192, 16'sd8192, 16'sd8192);
        offer_angles(-16'sd8192, 16'sd24576, -16'sd24576);
        offer_angles(16'sd16384, -16'sd16384, 16'sd0);
        offer_angles(16'sd0, 16'sd16384, -16'sd16384);
        offer_angles(-16'sd32768, 16'sd16384, 16'sd16384);
        offer_angles(16'sd16384, -16'sd32768, 16'sd16384);
        offer_angles(16'sd16384, 16'sd16384, -16'sd32768);
        offer_angles(16'sd21845, -16'sd10923, 16'sd5461);
        offer_angles(16'sh5555, -16'sh5556, 16'sh2aaa);
        wait_all_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                tx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (i == RANDOM_ITEMS / 2) begin
                wait_all_results();
            end
            offer_angles(random_angle(), random_angle(), random_angle());
        end
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int wait_cycles;
        bit long_hold_done;
        long_hold_done = 1'b0;
        matrix_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_taken % 64 == 0) begin
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (results_taken == HOLD_AT && !long_hold_done) begin
                long_hold_done = 1'b1;
                wait_cycles    = LONG_HOLD;
            end else begin
                wait_cycles = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (wait_cycles > 0) begin
                matrix_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            matrix_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!matrix_ch.valid) @(posedge i_clk);
            results_taken++;
        end
    end

endmodule
